### src/button_click_hold_detector_assert.svh
// assertion macros for the button click and hold detector
// each macro expects clk_i and rst_ni in the scope where it is used
`ifndef BUTTON_CLICK_HOLD_DETECTOR_ASSERT_SVH
`define BUTTON_CLICK_HOLD_DETECTOR_ASSERT_SVH

`ifndef SYNTHESIS

// property that holds at every edge outside reset
`define BCHD_ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error("button detector check failed");

// consequence that must hold in the cycle after the antecedent
`define BCHD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("button detector check failed");

`else

`define BCHD_ASSERT_ALWAYS(lbl, expr)
`define BCHD_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

### src/bchd_pkg.sv
package bchd_pkg;

  // event codes carried on the result stream
  typedef enum logic [1:0] {
    EV_HOLD    = 2'd0,
    EV_RELEASE = 2'd1,
    EV_MULTI   = 2'd2
  } event_kind_e;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_DEBOUNCE   = 2'd0,
    REG_MULTICLICK = 2'd1,
    REG_HOLD       = 2'd2,
    REG_ACTIVE     = 2'd3
  } reg_index_e;

  // pending events of one tick, in delivery order from the lowest bit up
  typedef struct packed {
    logic rel;
    logic multi;
    logic hold;
  } ev_mask_t;

  localparam logic [15:0] DEBOUNCE_RESET   = 16'd50;
  localparam logic [15:0] MULTICLICK_RESET = 16'd300;
  localparam logic [15:0] HOLD_RESET       = 16'd300;
  localparam logic        ACTIVE_RESET     = 1'b0;
  localparam logic [7:0]  CLICK_MAX        = 8'd255;

  // countdown length, zero counts as one tick
  function automatic logic [15:0] load_len(input logic [15:0] v);
    return (v == 16'd0) ? 16'd1 : v;
  endfunction

  // decrement that stops at zero
  function automatic logic [15:0] dec_sat(input logic [15:0] v);
    return (v == 16'd0) ? 16'd0 : v - 16'd1;
  endfunction

  // kind of the first event in a mask
  function automatic event_kind_e first_kind(input ev_mask_t m);
    if (m.hold) begin
      return EV_HOLD;
    end else if (m.multi) begin
      return EV_MULTI;
    end
    return EV_RELEASE;
  endfunction

  // mask with its first event removed
  function automatic ev_mask_t drop_first(input ev_mask_t m);
    logic [2:0] v;
    v = m;
    return ev_mask_t'(v & (v - 3'd1));
  endfunction

endpackage

### src/button_click_hold_detector.sv
// button click and hold detector, one input transaction per millisecond tick
// the first event of a tick enters the result register at accept when nothing waits
//   ahead of it, else it waits in the pending event register until those have left
// throughput: one tick per cycle while s_axis_tready is high; k events of a tick leave
//   one by one, the pending event register lets the next tick in while the last is shown
// reset: async active low, non-payload registers to defaults, all countdowns disarmed
module button_click_hold_detector (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream, tdata: [0] pin_level, [7:1] zero
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,
  // result stream, tdata: [7:0] clicks
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,
  // tuser: [1:0] event_kind
  output logic [1:0]  m_axis_tuser,
  output logic        m_axis_tlast,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import bchd_pkg::*;
  `include "button_click_hold_detector_assert.svh"

  // configuration registers
  logic [15:0] deb_ticks_q, multi_ticks_q, hold_ticks_q;
  logic        active_q;
  logic        cfg_wr;
  reg_index_e  cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = reg_index_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deb_ticks_q   <= DEBOUNCE_RESET;
      multi_ticks_q <= MULTICLICK_RESET;
      hold_ticks_q  <= HOLD_RESET;
      active_q      <= ACTIVE_RESET;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_DEBOUNCE:   deb_ticks_q   <= pwdata[15:0];
        REG_MULTICLICK: multi_ticks_q <= pwdata[15:0];
        REG_HOLD:       hold_ticks_q  <= pwdata[15:0];
        REG_ACTIVE:     active_q      <= pwdata[0];
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    case (cfg_idx)
      REG_DEBOUNCE:   prdata = {16'd0, deb_ticks_q};
      REG_MULTICLICK: prdata = {16'd0, multi_ticks_q};
      REG_HOLD:       prdata = {16'd0, hold_ticks_q};
      REG_ACTIVE:     prdata = {31'd0, active_q};
      default:        prdata = 32'd0;
    endcase
  end

  // detector state
  logic        prev_q, prev_d;
  logic [15:0] deb_left_q, deb_left_d, hold_left_q, hold_left_d;
  logic [15:0] multi_left_q, multi_left_d;
  logic        deb_arm_q, deb_arm_d, hold_arm_q, hold_arm_d;
  logic        multi_arm_q, multi_arm_d;
  logic [7:0]  click_q, click_d;

  // pending events and output register
  ev_mask_t    pend_q, pend_d;
  logic [7:0]  pend_clicks_q, pend_clicks_d;
  logic        out_valid_q, out_valid_d;
  event_kind_e out_kind_q, out_kind_d;
  logic [7:0]  out_clicks_q, out_clicks_d;
  logic        out_last_q, out_last_d;

  logic        accept, out_load, level;
  logic [15:0] hold_dec, multi_dec, deb_dec;
  logic        hold_exp, multi_exp, deb_exp, release_ev;
  ev_mask_t    new_mask;

  assign level    = s_axis_tdata[0];
  assign out_load = !out_valid_q || m_axis_tready;
  // room when nothing waits, or the single waiting event leaves this cycle
  assign s_axis_tready = (pend_q == '0) ||
                         (out_load && (drop_first(pend_q) == '0));
  assign accept   = s_axis_tvalid & s_axis_tready;

  // countdown decrement and expiry
  assign hold_dec   = dec_sat(hold_left_q);
  assign multi_dec  = dec_sat(multi_left_q);
  assign deb_dec    = dec_sat(deb_left_q);
  assign hold_exp   = hold_arm_q && (hold_dec == 16'd0);
  assign multi_exp  = multi_arm_q && (multi_dec == 16'd0);
  assign deb_exp    = deb_arm_q && (deb_dec == 16'd0);
  assign release_ev = deb_exp && (level != active_q);

  assign new_mask.hold  = hold_exp;
  assign new_mask.multi = multi_exp;
  assign new_mask.rel   = release_ev;

  // state update for an accepted tick
  always_comb begin
    prev_d       = prev_q;
    deb_left_d   = deb_left_q;
    deb_arm_d    = deb_arm_q;
    hold_left_d  = hold_left_q;
    hold_arm_d   = hold_arm_q;
    multi_left_d = multi_left_q;
    multi_arm_d  = multi_arm_q;
    click_d      = click_q;
    if (accept) begin
      // decrement armed countdowns, expiry disarms
      if (hold_arm_q) begin
        hold_left_d = hold_dec;
        hold_arm_d  = !hold_exp;
      end
      if (multi_arm_q) begin
        multi_left_d = multi_dec;
        multi_arm_d  = !multi_exp;
      end
      if (deb_arm_q) begin
        deb_left_d = deb_dec;
        deb_arm_d  = !deb_exp;
      end
      // multi-click report clears the count
      if (multi_exp) begin
        click_d = 8'd0;
      end
      // debounce judgement
      if (deb_exp) begin
        if (level == active_q) begin
          hold_arm_d  = 1'b1;
          hold_left_d = load_len(hold_ticks_q);
        end else begin
          hold_arm_d   = 1'b0;
          hold_left_d  = 16'd0;
          multi_arm_d  = 1'b1;
          multi_left_d = load_len(multi_ticks_q);
          if (click_d != CLICK_MAX) begin
            click_d = click_d + 8'd1;
          end
        end
      end
      // level change restarts debounce
      if (level != prev_q) begin
        deb_arm_d  = 1'b1;
        deb_left_d = load_len(deb_ticks_q);
        prev_d     = level;
      end
    end
  end

  // event queue: output register fed from pending events or straight from the tick
  always_comb begin
    pend_d        = pend_q;
    pend_clicks_d = pend_clicks_q;
    out_valid_d   = out_valid_q;
    out_kind_d    = out_kind_q;
    out_clicks_d  = out_clicks_q;
    out_last_d    = out_last_q;
    if (out_load) begin
      out_valid_d = 1'b0;
      if (pend_q != '0) begin
        out_valid_d  = 1'b1;
        out_kind_d   = first_kind(pend_q);
        out_clicks_d = (first_kind(pend_q) == EV_MULTI) ? pend_clicks_q : 8'd0;
        out_last_d   = (drop_first(pend_q) == '0);
        pend_d       = drop_first(pend_q);
        if (accept) begin
          pend_d        = new_mask;
          pend_clicks_d = click_q;
        end
      end else if (accept && (new_mask != '0)) begin
        out_valid_d   = 1'b1;
        out_kind_d    = first_kind(new_mask);
        out_clicks_d  = (first_kind(new_mask) == EV_MULTI) ? click_q : 8'd0;
        out_last_d    = (drop_first(new_mask) == '0);
        pend_d        = drop_first(new_mask);
        pend_clicks_d = click_q;
      end
    end else if (accept) begin
      pend_d        = new_mask;
      pend_clicks_d = click_q;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q       <= ~ACTIVE_RESET;
      deb_left_q   <= 16'd0;
      deb_arm_q    <= 1'b0;
      hold_left_q  <= 16'd0;
      hold_arm_q   <= 1'b0;
      multi_left_q <= 16'd0;
      multi_arm_q  <= 1'b0;
      click_q      <= 8'd0;
      pend_q       <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      prev_q       <= prev_d;
      deb_left_q   <= deb_left_d;
      deb_arm_q    <= deb_arm_d;
      hold_left_q  <= hold_left_d;
      hold_arm_q   <= hold_arm_d;
      multi_left_q <= multi_left_d;
      multi_arm_q  <= multi_arm_d;
      click_q      <= click_d;
      pend_q       <= pend_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    pend_clicks_q <= pend_clicks_d;
    out_kind_q    <= out_kind_d;
    out_clicks_q  <= out_clicks_d;
    out_last_q    <= out_last_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_clicks_q;
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tlast  = out_last_q;

  // pending events never wait behind an empty output register
  `BCHD_ASSERT_ALWAYS(a_pend_has_out, (pend_q == '0) || out_valid_q)
  // a result that is not last of its tick has more events queued behind it
  `BCHD_ASSERT_ALWAYS(a_not_last_pending, !out_valid_q || out_last_q || (pend_q != '0))
  // a report without a release in the same tick leaves the count cleared
  `BCHD_ASSERT_NEXT(a_report_clears, accept && multi_exp && !release_ev, click_q == 8'd0)

endmodule

### verif/tb.sv
`timescale 1ns / 1ps

module tb;
  import bchd_pkg::*;

  localparam int STALL_LIMIT = 2000;
  // pin levels of the directed part, sent from the lowest bit up
  localparam logic [21:0] DIR_PATTERN = 22'b0110100110011110101000;

  // one expected event on the result stream
  typedef struct {
    event_kind_e kind;
    logic [7:0]  clicks;
    logic        last;
  } button_event_t;

  // tracks detector state and holds the events still due from the dut
  class click_event_tracker;
    button_event_t due_events[$];
    logic [15:0] deb_len, multi_len, hold_len;
    logic        act_lvl;
    logic        prev_lvl;
    logic [15:0] deb_left, hold_left, multi_left;
    bit          deb_on, hold_on, multi_on;
    logic [7:0]  click_tally;

    function new();
      deb_len     = 16'd50;
      multi_len   = 16'd300;
      hold_len    = 16'd300;
      act_lvl     = 1'b0;
      prev_lvl    = 1'b1;
      deb_left    = '0;
      hold_left   = '0;
      multi_left  = '0;
      deb_on      = 1'b0;
      hold_on     = 1'b0;
      multi_on    = 1'b0;
      click_tally = '0;
    endfunction

    // a zero length still takes one tick
    function logic [15:0] reload(logic [15:0] v);
      return (v == 16'd0) ? 16'd1 : v;
    endfunction

    // one tick of a countdown, returns {expired, remaining}
    function logic [16:0] run_down(bit on, logic [15:0] left);
      logic [15:0] nxt;
      if (!on) begin
        return {1'b0, left};
      end
      nxt = (left == 16'd0) ? 16'd0 : left - 16'd1;
      return {nxt == 16'd0, nxt};
    endfunction

    function void set_reg(reg_index_e idx, logic [31:0] v);
      case (idx)
        REG_DEBOUNCE:   deb_len   = v[15:0];
        REG_MULTICLICK: multi_len = v[15:0];
        REG_HOLD:       hold_len  = v[15:0];
        REG_ACTIVE:     act_lvl   = v[0];
        default: ;
      endcase
    endfunction

    function logic [31:0] reg_value(reg_index_e idx);
      case (idx)
        REG_DEBOUNCE:   return {16'd0, deb_len};
        REG_MULTICLICK: return {16'd0, multi_len};
        REG_HOLD:       return {16'd0, hold_len};
        default:        return {31'd0, act_lvl};
      endcase
    endfunction

    // advance one tick and queue the events it causes
    function void note_tick(logic lvl);
      button_event_t fresh[$];
      button_event_t ev;
      logic [16:0] r;
      bit hold_x, multi_x, deb_x;
      r = run_down(hold_on, hold_left);
      hold_x = r[16];
      hold_left = r[15:0];
      if (hold_x) hold_on = 1'b0;
      r = run_down(multi_on, multi_left);
      multi_x = r[16];
      multi_left = r[15:0];
      if (multi_x) multi_on = 1'b0;
      r = run_down(deb_on, deb_left);
      deb_x = r[16];
      deb_left = r[15:0];
      if (deb_x) deb_on = 1'b0;

      if (hold_x) begin
        ev.kind = EV_HOLD; ev.clicks = 8'd0; ev.last = 1'b0;
        fresh.push_back(ev);
      end
      if (multi_x) begin
        ev.kind = EV_MULTI; ev.clicks = click_tally; ev.last = 1'b0;
        fresh.push_back(ev);
        click_tally = 8'd0;
      end
      // debounce judgement on this tick's level
      if (deb_x) begin
        if (lvl == act_lvl) begin
          hold_on = 1'b1;
          hold_left = reload(hold_len);
        end else begin
          hold_on = 1'b0;
          hold_left = 16'd0;
          ev.kind = EV_RELEASE; ev.clicks = 8'd0; ev.last = 1'b0;
          fresh.push_back(ev);
          if (click_tally != 8'hff) click_tally = click_tally + 8'd1;
          multi_on = 1'b1;
          multi_left = reload(multi_len);
        end
      end
      if (lvl != prev_lvl) begin
        deb_on = 1'b1;
        deb_left = reload(deb_len);
        prev_lvl = lvl;
      end

      for (int i = 0; i < fresh.size(); i++) begin
        ev = fresh[i];
        ev.last = (i == fresh.size() - 1);
        due_events.push_back(ev);
      end
    endfunction

    // compare one result transaction with the oldest due event
    function string check_event(event_kind_e k, logic [7:0] c, logic l);
      button_event_t ev;
      if (due_events.size() == 0) begin
        return $sformatf("unexpected event kind %0d clicks %0d last %0b", k, c, l);
      end
      ev = due_events.pop_front();
      if (k !== ev.kind || c !== ev.clicks || l !== ev.last) begin
        return $sformatf("event got kind %0d clicks %0d last %0b, exp kind %0d clicks %0d last %0b",
                         k, c, l, ev.kind, ev.clicks, ev.last);
      end
      return "";
    endfunction

    function int pending();
      return due_events.size();
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // tdata: [0] pin_level, [7:1] zero
  logic [7:0]  s_axis_tdata = 8'd0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // tdata: [7:0] clicks
  logic [7:0]  m_axis_tdata;
  // tuser: [1:0] event_kind
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = 4'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  click_event_tracker tracker;
  int errors = 0;
  int tx_count = 0;
  int rx_count = 0;
  int quiet_cycles = 0;

  button_click_hold_detector u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  task automatic report(input string msg);
    errors++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // one apb transaction: setup, access, then idle
  task automatic apb_access(input logic wr, input reg_index_e idx, input logic [31:0] wdat,
                            output logic [31:0] rdat);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdat;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdat = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic reg_check(input reg_index_e idx);
    logic [31:0] rd;
    apb_access(1'b0, idx, 32'd0, rd);
    if (rd !== tracker.reg_value(idx)) begin
      report($sformatf("register %0d read %0h, exp %0h", idx, rd, tracker.reg_value(idx)));
    end
  endtask

  task automatic cfg_write(input reg_index_e idx, input logic [31:0] val);
    logic [31:0] rd;
    apb_access(1'b1, idx, val, rd);
    tracker.set_reg(idx, val);
    reg_check(idx);
  endtask

  // one tick transaction, with a random gap outside the calm stretches
  task automatic send_tick(input logic lvl);
    int gap;
    gap = (tx_count % 48 < 16) ? 0 : $urandom_range(0, 13);
    tx_count++;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, lvl};
    do @(posedge clk_i); while (!s_axis_tready);
    tracker.note_tick(lvl);
  endtask

  // stop sending and let every due event arrive
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // result side backpressure
  initial begin
    int stall;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      stall = (rx_count % 48 < 16) ? 0 : $urandom_range(0, 13);
      rx_count++;
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    string msg;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      msg = tracker.check_event(event_kind_e'(m_axis_tuser), m_axis_tdata, m_axis_tlast);
      if (msg != "") report(msg);
    end
  end

  // watchdog on cycles with no transaction anywhere
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("button_click_hold_detector verification failed");
      $finish;
    end
  end

  // stimulus
  initial begin
    int deb, multi, hold, act, span, run;
    logic lvl, glitch;
    tracker = new();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset values, then the top of each range
    for (int i = 0; i < 4; i++) reg_check(reg_index_e'(i));
    cfg_write(REG_DEBOUNCE, 32'hffff);
    cfg_write(REG_MULTICLICK, 32'hffff);
    cfg_write(REG_HOLD, 32'hffff);
    cfg_write(REG_ACTIVE, 32'd1);

    // zero lengths act as one tick; release before any press, holds, reports
    cfg_write(REG_DEBOUNCE, 32'd0);
    cfg_write(REG_MULTICLICK, 32'd0);
    cfg_write(REG_HOLD, 32'd0);
    for (int i = 0; i < 22; i++) send_tick(DIR_PATTERN[i]);
    settle();

    // many clicks in a row: a release every other tick keeps the report away
    cfg_write(REG_DEBOUNCE, 32'd1);
    cfg_write(REG_MULTICLICK, 32'd3);
    cfg_write(REG_ACTIVE, 32'd0);
    for (int i = 0; i < 60; i++) send_tick(i[0]);
    for (int i = 0; i < 6; i++) send_tick(1'b1);
    settle();

    // random phases of press and release runs with some bounce
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin deb = 1; multi = 65535; hold = 1; act = 0; end
        1: begin deb = 2; multi = 1; hold = 65535; act = 1; end
        default: begin
          deb   = $urandom_range(0, 4);
          multi = $urandom_range(0, 14);
          hold  = $urandom_range(0, 14);
          act   = $urandom_range(0, 1);
        end
      endcase
      cfg_write(REG_DEBOUNCE, deb);
      cfg_write(REG_MULTICLICK, multi);
      cfg_write(REG_HOLD, hold);
      cfg_write(REG_ACTIVE, act);
      span = deb + hold + 3;
      if (span > 30) span = 30;
      lvl = 1'($urandom_range(0, 1));
      run = 0;
      for (int n = 0; n < 58; n++) begin
        if (run == 0) begin
          if ($urandom_range(0, 5) != 0) lvl = ~lvl;
          run = $urandom_range(1, span);
        end
        glitch = ($urandom_range(0, 9) == 0);
        send_tick(glitch ? ~lvl : lvl);
        run--;
        if ($urandom_range(0, 39) == 0) settle();
      end
      settle();
    end

    repeat (8) @(posedge clk_i);
    if (tracker.pending() != 0) report($sformatf("%0d events never arrived", tracker.pending()));
    if (errors == 0) begin
      $display("button_click_hold_detector verification clean");
    end else begin
      $display("button_click_hold_detector verification failed");
    end
    $finish;
  end

endmodule
